// File: rtl/coap_od_pkg.sv
package coap_od_pkg;

  // Width of the saturating message byte counter
  localparam int unsigned LENGTH_BITS = 16;
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

  localparam int unsigned OPT_BITS = 17;
  localparam logic [OPT_BITS-1:0] OPT_MAX = {OPT_BITS{1'b1}};

  localparam logic [7:0]  VERSION_MASK   = 8'h40;
  localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
  localparam logic [3:0]  TOKEN_MAX      = 4'd8;
  localparam int unsigned HEADER_BYTES   = 4;

  localparam logic [3:0] NIB_EXT8  = 4'd13;
  localparam logic [3:0] NIB_EXT16 = 4'd14;
  localparam logic [3:0] NIB_BAD   = 4'd15;

  localparam logic [OPT_BITS-1:0] EXT8_BIAS  = OPT_BITS'(13);
  localparam logic [OPT_BITS-1:0] EXT16_BIAS = OPT_BITS'(269);

  localparam logic [15:0] TARGET_RESET = 16'd9;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TOKEN,
    PH_OPT,
    PH_DELTA1,
    PH_DELTA2,
    PH_LEN1,
    PH_LEN2,
    PH_VALUE
  } phase_e;

  typedef enum logic [1:0] {
    V_FOUND,
    V_ABSENT,
    V_MALFORMED,
    V_BADVER
  } verdict_e;

endpackage

// File: rtl/coap_od_byte_if.sv
interface coap_od_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/coap_od_verdict_if.sv
interface coap_od_verdict_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink (input valid, input verdict, output ready);
endinterface

// File: rtl/coap_oscore_option_detector.sv
// Channel     Dir  Payload                       Transfer
// byte_i      in   data_byte[7:0], last_byte     valid & ready
// verdict_o   out  verdict[1:0]                  valid & ready
// cfg         in   cfg_wdata_i[15:0]             cfg_we_i (target_option)
//
// One byte per cycle while byte_i.ready is high: each byte updates the parse state in the cycle it is taken.
// A verdict appears in the output register in the cycle after the last byte is taken.
// A new byte is taken while the output register is empty or being drained.
// Reset clears the parse state and loads target_option with 9.
module coap_oscore_option_detector (
  input  logic                clk_i,
  input  logic                rst_ni,
  coap_od_byte_if.sink        byte_i,
  coap_od_verdict_if.source   verdict_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i
);
  import coap_od_pkg::*;

  logic [15:0]            target_q;
  phase_e                 phase_q, phase_d, phase_n;
  logic [LENGTH_BITS-1:0] count_q, count_d, count_n;
  logic [3:0]             tok_q, tok_d, tok_n;
  logic [OPT_BITS-1:0]    opt_q, opt_d, opt_n;
  logic [3:0]             dnib_q, dnib_d, dnib_n;
  logic [3:0]             lnib_q, lnib_d, lnib_n;
  logic [15:0]            ext_q, ext_d, ext_n;
  logic [OPT_BITS-1:0]    skip_q, skip_d, skip_n;
  verdict_e               dv_q, dv_d, dv_n;
  logic                   dec_q, dec_d, dec_n;
  logic                   out_valid_q, out_valid_d;
  verdict_e               out_verdict_q, out_verdict_d;

  logic                   in_fire;
  logic [7:0]             b;
  logic [OPT_BITS-1:0]    delta_amt;
  logic [OPT_BITS:0]      opt_sum;
  logic [OPT_BITS-1:0]    opt_sat;
  logic [OPT_BITS-1:0]    len_val;
  logic [OPT_BITS-1:0]    opt_cmp;
  logic [15:0]            ext_wide;
  logic                   use_delta;
  logic                   do_finish;
  verdict_e               msg_verdict;

  assign b       = byte_i.data_byte;
  assign in_fire = byte_i.valid && byte_i.ready;
  assign byte_i.ready = !out_valid_q || verdict_o.ready;

  assign verdict_o.valid   = out_valid_q;
  assign verdict_o.verdict = out_verdict_q;

  // Datapath for delta accumulation and decoded length
  assign ext_wide = {ext_q[7:0], b};
  always_comb begin
    case (phase_q)
      PH_DELTA1: delta_amt = {{(OPT_BITS-8){1'b0}}, b} + EXT8_BIAS;
      PH_DELTA2: delta_amt = {{(OPT_BITS-16){1'b0}}, ext_wide} + EXT16_BIAS;
      default:   delta_amt = {{(OPT_BITS-4){1'b0}}, b[7:4]};
    endcase
  end
  assign opt_sum = {1'b0, opt_q} + {1'b0, delta_amt};
  assign opt_sat = opt_sum[OPT_BITS] ? OPT_MAX : opt_sum[OPT_BITS-1:0];

  // Next parse state for one byte
  always_comb begin
    phase_n = phase_q;
    count_n = (count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
    tok_n   = tok_q;
    opt_n   = opt_q;
    dnib_n  = dnib_q;
    lnib_n  = lnib_q;
    ext_n   = ext_q;
    skip_n  = skip_q;
    dv_n    = dv_q;
    dec_n   = dec_q;
    use_delta = 1'b0;
    do_finish = 1'b0;
    len_val   = {{(OPT_BITS-4){1'b0}}, lnib_q};

    if (!dec_q) begin
      case (phase_q)
        PH_HEADER: begin
          if (count_q == '0) begin
            if ((b & VERSION_MASK) != VERSION_MASK) begin
              dv_n  = V_BADVER;
              dec_n = 1'b1;
            end else begin
              tok_n = b[3:0];
              if (b[3:0] > TOKEN_MAX) begin
                dv_n  = V_MALFORMED;
                dec_n = 1'b1;
              end
            end
          end else if (count_q >= LENGTH_BITS'(HEADER_BYTES - 1)) begin
            phase_n = (tok_q == '0) ? PH_OPT : PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          if (count_n >= LENGTH_BITS'(HEADER_BYTES) + LENGTH_BITS'(tok_q)) begin
            phase_n = PH_OPT;
          end
        end
        PH_OPT: begin
          dnib_n = b[7:4];
          lnib_n = b[3:0];
          if (b == PAYLOAD_MARKER) begin
            dv_n  = V_ABSENT;
            dec_n = 1'b1;
          end else if (b[7:4] == NIB_BAD || b[3:0] == NIB_BAD) begin
            dv_n  = V_MALFORMED;
            dec_n = 1'b1;
          end else if (b[7:4] == NIB_EXT8 || b[7:4] == NIB_EXT16) begin
            ext_n   = '0;
            phase_n = PH_DELTA1;
          end else begin
            use_delta = 1'b1;
          end
        end
        PH_DELTA1: begin
          ext_n = {8'h00, b};
          if (dnib_q == NIB_EXT8) begin
            use_delta = 1'b1;
          end else begin
            phase_n = PH_DELTA2;
          end
        end
        PH_DELTA2: begin
          ext_n     = ext_wide;
          use_delta = 1'b1;
        end
        PH_LEN1: begin
          ext_n = {8'h00, b};
          if (lnib_q == NIB_EXT8) begin
            len_val   = {{(OPT_BITS-8){1'b0}}, b} + EXT8_BIAS;
            do_finish = 1'b1;
          end else begin
            phase_n = PH_LEN2;
          end
        end
        PH_LEN2: begin
          ext_n     = ext_wide;
          len_val   = {{(OPT_BITS-16){1'b0}}, ext_wide} + EXT16_BIAS;
          do_finish = 1'b1;
        end
        PH_VALUE: begin
          skip_n = (skip_q != '0) ? skip_q - 1'b1 : skip_q;
          if (skip_n == '0) begin
            phase_n = PH_OPT;
          end
        end
        default: begin
          phase_n = phase_q;
        end
      endcase

      // After the delta: extended length bytes follow, or the header is done
      if (use_delta) begin
        opt_n = opt_sat;
        if (lnib_n == NIB_EXT8 || lnib_n == NIB_EXT16) begin
          ext_n   = '0;
          phase_n = PH_LEN1;
        end else begin
          len_val   = {{(OPT_BITS-4){1'b0}}, lnib_n};
          do_finish = 1'b1;
        end
      end

      opt_cmp = opt_n;
      if (do_finish) begin
        if (opt_cmp == {{(OPT_BITS-16){1'b0}}, target_q}) begin
          dv_n  = V_FOUND;
          dec_n = 1'b1;
        end else begin
          skip_n  = len_val;
          phase_n = (len_val == '0) ? PH_OPT : PH_VALUE;
        end
      end
    end else begin
      count_n = count_q;
    end
    opt_cmp = opt_n;
  end

  // Verdict for a message that ends on this byte
  always_comb begin
    if (dec_n) begin
      msg_verdict = dv_n;
    end else if (phase_n == PH_OPT || phase_n == PH_VALUE) begin
      msg_verdict = V_ABSENT;
    end else begin
      msg_verdict = V_MALFORMED;
    end
  end

  // Commit on a transfer; a last byte returns the parse state to reset values
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    tok_d   = tok_q;
    opt_d   = opt_q;
    dnib_d  = dnib_q;
    lnib_d  = lnib_q;
    ext_d   = ext_q;
    skip_d  = skip_q;
    dv_d    = dv_q;
    dec_d   = dec_q;
    if (in_fire) begin
      if (byte_i.last_byte) begin
        phase_d = PH_HEADER;
        count_d = '0;
        tok_d   = '0;
        opt_d   = '0;
        dnib_d  = '0;
        lnib_d  = '0;
        ext_d   = '0;
        skip_d  = '0;
        dv_d    = V_ABSENT;
        dec_d   = 1'b0;
      end else begin
        phase_d = phase_n;
        count_d = count_n;
        tok_d   = tok_n;
        opt_d   = opt_n;
        dnib_d  = dnib_n;
        lnib_d  = lnib_n;
        ext_d   = ext_n;
        skip_d  = skip_n;
        dv_d    = dv_n;
        dec_d   = dec_n;
      end
    end
  end

  always_comb begin
    out_valid_d   = out_valid_q && !verdict_o.ready;
    out_verdict_d = out_verdict_q;
    if (in_fire && byte_i.last_byte) begin
      out_valid_d   = 1'b1;
      out_verdict_d = msg_verdict;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= TARGET_RESET;
      phase_q     <= PH_HEADER;
      count_q     <= '0;
      tok_q       <= '0;
      opt_q       <= '0;
      dnib_q      <= '0;
      lnib_q      <= '0;
      ext_q       <= '0;
      skip_q      <= '0;
      dv_q        <= V_ABSENT;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      phase_q     <= phase_d;
      count_q     <= count_d;
      tok_q       <= tok_d;
      opt_q       <= opt_d;
      dnib_q      <= dnib_d;
      lnib_q      <= lnib_d;
      ext_q       <= ext_d;
      skip_q      <= skip_d;
      dv_q        <= dv_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_verdict_q <= out_verdict_d;
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && byte_i.last_byte |=> out_valid_q && phase_q == PH_HEADER && count_q == '0
      && !dec_q)
    else $error("parse state not cleared after last byte");

  a_decided_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_q && in_fire && !byte_i.last_byte |=> dec_q && $stable(dv_q) && $stable(phase_q))
    else $error("settled verdict changed within a message");

  a_value_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_VALUE |-> skip_q != '0)
    else $error("value phase with nothing left to skip");

  a_first_byte_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> phase_q == PH_HEADER && !dec_q)
    else $error("parse advanced without a counted byte");

endmodule

// File: test/tb_coap_oscore_option_detector.sv
`timescale 1ns / 100ps

module tb_coap_oscore_option_detector;
  import coap_od_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_BYTES = 1700;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TARGET_SETS  = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  coap_od_byte_if    byte_ch ();
  coap_od_verdict_if verdict_ch ();

  coap_oscore_option_detector dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_ch),
    .verdict_o  (verdict_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #1 clk_i = ~clk_i;

  bit          gap_on = 1'b1;
  bit          stall_on = 1'b1;
  int unsigned err_count = 0;
  int unsigned cycles = 0;
  int unsigned sent_bytes = 0;

  // Parser copy: follows the block byte by byte
  logic [15:0]            target_opt;
  phase_e                 ph;
  logic [LENGTH_BITS-1:0] msg_count;
  logic [3:0]             tkn_len;
  logic [3:0]             dnib;
  logic [3:0]             lnib;
  logic [OPT_BITS-1:0]    opt_num;
  logic [OPT_BITS-1:0]    skip_left;
  logic [15:0]            ext_val;
  verdict_e               held_verdict;
  bit                     settled;

  verdict_e verdict_q[$];

  // Message under construction
  logic [7:0]  pkt[$];
  int unsigned pkt_opt = 0;

  function automatic void clear_parse();
    ph           = PH_HEADER;
    msg_count    = '0;
    tkn_len      = '0;
    dnib         = '0;
    lnib         = '0;
    opt_num      = '0;
    skip_left    = '0;
    ext_val      = '0;
    held_verdict = V_ABSENT;
    settled      = 1'b0;
  endfunction

  function automatic void settle(input verdict_e v);
    held_verdict = v;
    settled      = 1'b1;
  endfunction

  function automatic void add_delta(input logic [OPT_BITS-1:0] d);
    logic [OPT_BITS:0] sum;
    sum = {1'b0, opt_num} + {1'b0, d};
    opt_num = (sum > {1'b0, OPT_MAX}) ? OPT_MAX : sum[OPT_BITS-1:0];
  endfunction

  function automatic void finish_header(input logic [OPT_BITS-1:0] len);
    if (opt_num == {1'b0, target_opt}) begin
      settle(V_FOUND);
      return;
    end
    skip_left = len;
    ph = (len == '0) ? PH_OPT : PH_VALUE;
  endfunction

  function automatic void after_delta();
    if (lnib == NIB_EXT8 || lnib == NIB_EXT16) begin
      ext_val = '0;
      ph = PH_LEN1;
    end else begin
      finish_header(OPT_BITS'(lnib));
    end
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    logic [LENGTH_BITS-1:0] idx;
    idx = msg_count;
    if (msg_count != COUNT_MAX)
      msg_count++;
    case (ph)
      PH_HEADER: begin
        if (idx == 0) begin
          if ((b & VERSION_MASK) != VERSION_MASK) begin
            settle(V_BADVER);
            return;
          end
          tkn_len = b[3:0];
          if (tkn_len > TOKEN_MAX) begin
            settle(V_MALFORMED);
            return;
          end
        end
        if (idx >= HEADER_BYTES - 1)
          ph = (tkn_len == 0) ? PH_OPT : PH_TOKEN;
      end
      PH_TOKEN: begin
        if (msg_count >= HEADER_BYTES + tkn_len)
          ph = PH_OPT;
      end
      PH_OPT: begin
        if (b == PAYLOAD_MARKER) begin
          settle(V_ABSENT);
          return;
        end
        dnib = b[7:4];
        lnib = b[3:0];
        if (dnib == NIB_BAD || lnib == NIB_BAD) begin
          settle(V_MALFORMED);
          return;
        end
        if (dnib == NIB_EXT8 || dnib == NIB_EXT16) begin
          ext_val = '0;
          ph = PH_DELTA1;
        end else begin
          add_delta(OPT_BITS'(dnib));
          after_delta();
        end
      end
      PH_DELTA1: begin
        ext_val = {8'h00, b};
        if (dnib == NIB_EXT8) begin
          add_delta(OPT_BITS'(ext_val) + EXT8_BIAS);
          after_delta();
        end else begin
          ph = PH_DELTA2;
        end
      end
      PH_DELTA2: begin
        ext_val = {ext_val[7:0], b};
        add_delta(OPT_BITS'(ext_val) + EXT16_BIAS);
        after_delta();
      end
      PH_LEN1: begin
        ext_val = {8'h00, b};
        if (lnib == NIB_EXT8)
          finish_header(OPT_BITS'(ext_val) + EXT8_BIAS);
        else
          ph = PH_LEN2;
      end
      PH_LEN2: begin
        ext_val = {ext_val[7:0], b};
        finish_header(OPT_BITS'(ext_val) + EXT16_BIAS);
      end
      default: begin
        if (skip_left > 0)
          skip_left--;
        if (skip_left == 0)
          ph = PH_OPT;
      end
    endcase
  endfunction

  // Returns 1 when the byte closes a message; v then holds its verdict
  function automatic bit predict_verdict(input logic [7:0] b, input logic is_last,
                                         output verdict_e v);
    v = V_ABSENT;
    if (!settled)
      take_byte(b);
    if (!is_last)
      return 1'b0;
    if (settled)
      v = held_verdict;
    else if (ph == PH_OPT || ph == PH_VALUE)
      v = V_ABSENT;
    else
      v = V_MALFORMED;
    clear_parse();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    verdict_e want;
    if (rst_ni) begin
      if (verdict_ch.valid && verdict_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with none pending", verdict_ch.verdict));
        end else begin
          want = verdict_q.pop_front();
          if (verdict_ch.verdict !== want)
            report_mismatch($sformatf("verdict %0d, predicted %s",
                                      verdict_ch.verdict, want.name()));
        end
      end
      if (byte_ch.valid && byte_ch.ready &&
          predict_verdict(byte_ch.data_byte, byte_ch.last_byte, want))
        verdict_q.push_back(want);
    end
  end

  always @(negedge clk_i) begin
    verdict_ch.ready <= !stall_on || ($urandom_range(99) >= 25);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while (gap_on && $urandom_range(99) < 25) begin
      @(negedge clk_i);
      byte_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= is_last;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  task automatic send_msg();
    for (int i = 0; i < pkt.size(); i++)
      send_byte(pkt[i], i == pkt.size() - 1);
    sent_bytes += pkt.size();
    pkt.delete();
    pkt_opt = 0;
  endtask

  // Drop valid and hold until every pending verdict has been checked
  task automatic drain_results();
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    while (verdict_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_target(input logic [15:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    target_opt = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic void put_bytes(input int unsigned n);
    repeat (n) pkt.push_back(8'($urandom));
  endfunction

  function automatic void put_header(input int unsigned tkl);
    pkt.push_back({1'($urandom), 1'b1, 2'($urandom), 4'(tkl)});
    put_bytes(HEADER_BYTES - 1 + tkl);
  endfunction

  function automatic logic [3:0] nibble_for(input int unsigned v);
    if (v >= 269)
      return NIB_EXT16;
    if (v >= 13)
      return NIB_EXT8;
    return 4'(v);
  endfunction

  function automatic void put_ext(input int unsigned v);
    if (v >= 269) begin
      pkt.push_back(8'((v - 269) >> 8));
      pkt.push_back(8'(v - 269));
    end else if (v >= 13) begin
      pkt.push_back(8'(v - 13));
    end
  endfunction

  function automatic void put_option(input int unsigned delta, input int unsigned len);
    pkt.push_back({nibble_for(delta), nibble_for(len)});
    put_ext(delta);
    put_ext(len);
    put_bytes(len);
    pkt_opt += delta;
  endfunction

  function automatic int unsigned rand_delta();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70)
      return $urandom_range(12);
    if (r < 95)
      return $urandom_range(268, 13);
    return $urandom_range(65804, 269);
  endfunction

  function automatic int unsigned rand_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75)
      return $urandom_range(4);
    if (r < 98)
      return $urandom_range(40, 5);
    return $urandom_range(300, 269);
  endfunction

  task automatic test_header_checks();
    pkt = '{8'h00};
    send_msg();
    // version bit clear, later bytes must not matter
    pkt = '{8'hBF, 8'h40, 8'hFF};
    send_msg();
    pkt = '{8'h49, 8'h00, 8'h00, 8'h00};
    send_msg();
    pkt = '{8'h4F};
    send_msg();
    pkt = '{8'h40, 8'h00};
    send_msg();
    put_header(8);
    repeat (3) void'(pkt.pop_back());
    send_msg();
    put_header(0);
    send_msg();
  endtask

  task automatic test_option_walk();
    put_header(0);
    put_option(9, 0);
    send_msg();
    put_header(2);
    put_option(268, 0);
    pkt.push_back(PAYLOAD_MARKER);
    put_bytes(3);
    send_msg();
    put_header(0);
    pkt.push_back(8'hF0);
    send_msg();
    put_header(0);
    pkt.push_back(8'h0F);
    send_msg();
    // end inside a 16-bit extended delta
    put_header(0);
    pkt.push_back(8'hE0);
    pkt.push_back(8'h12);
    send_msg();
    // end inside an 8-bit extended length
    put_header(1);
    pkt.push_back(8'h1D);
    send_msg();
    // target header complete, value runs past the end
    put_header(0);
    pkt = {pkt, 8'h9E, 8'hFF, 8'hFF};
    send_msg();
    put_header(8);
    put_option(5, 3);
    void'(pkt.pop_back());
    send_msg();
  endtask

  // Largest deltas: the option number saturates
  task automatic test_long_message();
    gap_on   = 1'b0;
    stall_on = 1'b0;
    put_header(0);
    put_option(65804, 2);
    put_option(65804, 0);
    put_option(65804, 0);
    pkt.push_back(PAYLOAD_MARKER);
    put_bytes(2);
    send_msg();
    gap_on   = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic random_message();
    int unsigned kind;
    int unsigned tkl;
    int unsigned delta;
    kind = $urandom_range(99);
    tkl  = $urandom_range(8);
    if (kind < 65) begin
      put_header(tkl);
      repeat ($urandom_range(4)) begin
        if (target_opt >= pkt_opt && $urandom_range(2) == 0)
          delta = target_opt - pkt_opt;
        else
          delta = rand_delta();
        put_option(delta, rand_len());
      end
      case ($urandom_range(2))
        0: ;
        1: begin
          pkt.push_back(PAYLOAD_MARKER);
          put_bytes($urandom_range(6));
        end
        default: begin
          repeat ($urandom_range(3, 1))
            if (pkt.size() > 1)
              void'(pkt.pop_back());
        end
      endcase
    end else if (kind < 75) begin
      put_header(tkl);
      if ($urandom_range(1))
        put_option(rand_delta(), rand_len());
      pkt.push_back($urandom_range(1) ? {4'hF, 4'($urandom)} : {4'($urandom), 4'hF});
      put_bytes($urandom_range(4));
    end else if (kind < 83) begin
      pkt.push_back({1'($urandom), 1'b0, 6'($urandom)});
      put_bytes($urandom_range(5));
    end else if (kind < 90) begin
      pkt.push_back({1'($urandom), 1'b1, 2'($urandom), 4'($urandom_range(15, 9))});
      put_bytes($urandom_range(6));
    end else begin
      put_bytes($urandom_range(12, 1));
    end
    send_msg();
  endtask

  task automatic test_random_traffic();
    logic [15:0] targets[TARGET_SETS];
    int unsigned first;
    targets = '{TARGET_RESET, 16'h0000, 16'hFFFF, 16'($urandom_range(40, 1)),
                16'($urandom_range(3000, 270)), 16'($urandom)};
    for (int p = 0; p < TARGET_SETS; p++) begin
      write_target(targets[p]);
      // one set runs back to back with no idling on either side
      gap_on   = (p != 1);
      stall_on = (p != 1);
      first    = sent_bytes;
      while (sent_bytes - first < RANDOM_BYTES / TARGET_SETS) begin
        random_message();
        if ($urandom_range(19) == 0)
          drain_results();
      end
    end
  endtask

  initial begin
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst_ni            = 1'b0;
    target_opt        = TARGET_RESET;
    clear_parse();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_header_checks();
    test_option_walk();
    test_long_message();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
rtl/coap_od_pkg.sv
rtl/coap_od_byte_if.sv
rtl/coap_od_verdict_if.sv
rtl/coap_oscore_option_detector.sv
test/tb_coap_oscore_option_detector.sv
